FILE: rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IVL_W  = 32;
  localparam int unsigned SID_W  = 4;
  localparam int unsigned TID_W  = 6;
  localparam int unsigned STAT_W = 3;

  localparam logic [CMD_W-1:0] CMD_ADD_TASK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REM_TASK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_SCHED = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_SCHED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_IVL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [TIME_W-1:0]       now;
    logic [SID_W-1:0]        schedule_id;
    logic [TID_W-1:0]        task_id;
    logic [TIME_W-1:0]       begin_time;
    logic signed [IVL_W-1:0] interval;
    logic                    repeat_req;
    logic                    fire_first;
  } ptt_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              fired;
    logic [SID_W-1:0]  fired_schedule;
    logic [TID_W-1:0]  fired_task;
    logic              task_started;
    logic              last;
  } ptt_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic step;
    logic finish;
  } ptt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_tick;
    logic fires;
    logic pend_valid;
    logic out_free;
  } ptt_stat_t;

endpackage

FILE: rtl/ptt_ctrl.sv
module ptt_ctrl #(
  parameter int unsigned Entries = 16,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output ptt_pkg::ptt_cmd_t   cmd_o,
  output logic [IdxW-1:0]     idx_o,
  input  ptt_pkg::ptt_stat_t  stat_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign idx_o      = idx_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.scan    = (state_q == S_SCAN);
    case (state_q)
      S_EXEC:  cmd_o.exec   = stat_i.out_free;
      // a firing entry needs the output stage only when a result is pending
      S_SCAN:  cmd_o.step   = !stat_i.fires || !stat_i.pend_valid || stat_i.out_free;
      S_FIN:   cmd_o.finish = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            idx_q   <= '0;
            state_q <= stat_i.in_is_tick ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.exec) state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (cmd_o.step) begin
            if (idx_q == LastIdx) state_q <= S_FIN;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_FIN: begin
          if (cmd_o.finish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ptt_dp.sv
module ptt_dp #(
  parameter int unsigned SCHEDULE_SLOTS = 16,
  parameter int unsigned TASK_IDS = 64,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned Entries = 16,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptt_pkg::ptt_in_t    in_data_i,
  input  ptt_pkg::ptt_cmd_t   cmd_i,
  input  logic [IdxW-1:0]     idx_i,
  output ptt_pkg::ptt_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptt_pkg::ptt_out_t   out_data_o
);

  localparam int unsigned TW    = TIME_BITS;
  localparam int unsigned NowW  = (TW > ptt_pkg::TIME_W) ? TW : ptt_pkg::TIME_W;
  localparam int unsigned SW    = NowW + 2;
  localparam int unsigned TidxW = (TASK_IDS > 1) ? $clog2(TASK_IDS) : 1;
  localparam int unsigned TextW = (TidxW > ptt_pkg::TID_W) ? TidxW : ptt_pkg::TID_W;

  // time + signed interval, saturated to the time range
  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t,
                                          input logic signed [ptt_pkg::IVL_W-1:0] v);
    logic signed [SW-1:0] s;
    s = $signed(SW'(t)) + SW'(v);
    if (s[SW-1]) tadd = '0;
    else if (|s[SW-2:TW]) tadd = '1;
    else tadd = s[TW-1:0];
  endfunction

  ptt_pkg::ptt_in_t in_q;

  logic [Entries-1:0]                valid_q;
  logic [ptt_pkg::TID_W-1:0]         task_q [Entries];
  logic [TW-1:0]                     due_q  [Entries];
  logic signed [ptt_pkg::IVL_W-1:0]  ivl_q  [Entries];
  logic [Entries-1:0]                rep_q;
  logic [Entries-1:0]                first_q;
  logic [TASK_IDS-1:0]               present_q;

  logic                 pend_valid_q;
  ptt_pkg::ptt_out_t    pend_q;
  logic                 out_valid_q;
  ptt_pkg::ptt_out_t    out_q;

  logic [NowW-1:0]      now_x, begin_x;
  logic [TW-1:0]        now_t, begin_t;
  logic                 sid_ok, tid_ok;
  logic [IdxW-1:0]      sidx, ridx;
  logic [TextW-1:0]     tid_x, etask_x;
  logic [TidxW-1:0]     taddr;
  logic                 present_rd;

  logic                             e_valid, e_first, e_rep;
  logic [ptt_pkg::TID_W-1:0]        e_task;
  logic [TW-1:0]                    e_due;
  logic signed [ptt_pkg::IVL_W-1:0] e_ivl, add_ivl;
  logic [TW-1:0]                    sum_now, sum_due, next_due;
  logic                             due_hit, fires;

  logic [ptt_pkg::STAT_W-1:0] status;
  logic                       cmd_ok;
  ptt_pkg::ptt_out_t          fire_res, quiet_res, cmd_res;
  logic                       out_load;
  ptt_pkg::ptt_out_t          out_d;

  assign now_x   = NowW'(in_q.now);
  assign begin_x = NowW'(in_q.begin_time);
  assign now_t   = now_x[TW-1:0];
  assign begin_t = begin_x[TW-1:0];

  assign sid_ok = 32'(in_q.schedule_id) < SCHEDULE_SLOTS;
  assign tid_ok = 32'(in_q.task_id) < TASK_IDS;
  assign sidx   = in_q.schedule_id[IdxW-1:0];
  assign tid_x  = TextW'(in_q.task_id);

  // one read port on the table: scan index during a tick, else the command's id
  assign ridx    = cmd_i.scan ? idx_i : sidx;
  assign e_valid = valid_q[ridx];
  assign e_first = first_q[ridx];
  assign e_rep   = rep_q[ridx];
  assign e_task  = task_q[ridx];
  assign e_due   = due_q[ridx];
  assign e_ivl   = ivl_q[ridx];

  assign etask_x    = TextW'(e_task);
  assign taddr      = cmd_i.scan ? etask_x[TidxW-1:0] : tid_x[TidxW-1:0];
  assign present_rd = present_q[taddr];

  assign add_ivl  = cmd_i.scan ? e_ivl : in_q.interval;
  assign sum_now  = tadd(now_t, add_ivl);
  assign sum_due  = tadd(e_due, e_ivl);
  assign next_due = (sum_due < now_t) ? sum_now : sum_due;
  assign due_hit  = (now_t >= e_due);
  assign fires    = e_valid && (e_first || due_hit);

  always_comb begin
    status = ptt_pkg::ST_OK;
    case (in_q.command)
      ptt_pkg::CMD_ADD_TASK: begin
        if (!tid_ok) status = ptt_pkg::ST_UNKNOWN;
        else if (present_rd) status = ptt_pkg::ST_PRESENT;
      end
      ptt_pkg::CMD_REM_TASK: begin
        if (!tid_ok || !present_rd) status = ptt_pkg::ST_NOT_FOUND;
      end
      ptt_pkg::CMD_ADD_SCHED: begin
        if (in_q.repeat_req && (in_q.interval <= 32'sd0)) status = ptt_pkg::ST_BAD_IVL;
        else if (!tid_ok || !present_rd) status = ptt_pkg::ST_UNKNOWN;
        else if (!sid_ok) status = ptt_pkg::ST_NOT_FOUND;
        else if (e_valid) status = ptt_pkg::ST_PRESENT;
      end
      ptt_pkg::CMD_REM_SCHED: begin
        if (!sid_ok || !e_valid) status = ptt_pkg::ST_NOT_FOUND;
      end
      default: status = ptt_pkg::ST_OK;
    endcase
  end

  assign cmd_ok = cmd_i.exec && (status == ptt_pkg::ST_OK);

  always_comb begin
    fire_res                = '0;
    fire_res.status         = ptt_pkg::ST_OK;
    fire_res.fired          = 1'b1;
    fire_res.fired_schedule = ptt_pkg::SID_W'(idx_i);
    fire_res.fired_task     = e_task;
    fire_res.task_started   = present_rd;

    quiet_res        = '0;
    quiet_res.status = ptt_pkg::ST_OK;
    quiet_res.last   = 1'b1;

    cmd_res        = quiet_res;
    cmd_res.status = status;

    out_load = 1'b0;
    out_d    = quiet_res;
    if (cmd_i.exec) begin
      out_load = 1'b1;
      out_d    = cmd_res;
    end else if (cmd_i.step && fires && pend_valid_q) begin
      out_load = 1'b1;
      out_d    = pend_q;
    end else if (cmd_i.finish) begin
      out_load = 1'b1;
      if (pend_valid_q) begin
        out_d      = pend_q;
        out_d.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      present_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_ok && in_q.command == ptt_pkg::CMD_ADD_TASK) present_q[taddr] <= 1'b1;
      if (cmd_ok && in_q.command == ptt_pkg::CMD_REM_TASK) present_q[taddr] <= 1'b0;
      if (cmd_ok && in_q.command == ptt_pkg::CMD_ADD_SCHED) valid_q[sidx] <= 1'b1;
      if (cmd_ok && in_q.command == ptt_pkg::CMD_REM_SCHED) valid_q[sidx] <= 1'b0;
      if (cmd_i.step && fires && !e_rep) valid_q[idx_i] <= 1'b0;

      if (cmd_i.step && fires) pend_valid_q <= 1'b1;
      else if (cmd_i.finish) pend_valid_q <= 1'b0;

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_ok && in_q.command == ptt_pkg::CMD_ADD_SCHED) begin
      task_q[sidx]  <= in_q.task_id;
      due_q[sidx]   <= (begin_t == '0) ? sum_now : begin_t;
      ivl_q[sidx]   <= in_q.interval;
      rep_q[sidx]   <= in_q.repeat_req;
      first_q[sidx] <= in_q.fire_first;
    end
    if (cmd_i.step && e_valid) begin
      if (e_first) first_q[idx_i] <= 1'b0;
      else if (due_hit) due_q[idx_i] <= next_due;
    end
    if (cmd_i.step && fires) pend_q <= fire_res;
    if (out_load) out_q <= out_d;
  end

  assign stat_o.in_is_tick = (in_data_i.command == ptt_pkg::CMD_TICK);
  assign stat_o.fires      = fires;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/periodic_task_timer_table.sv
// Timer table: a presence map of task ids and a table of schedule entries.
// Each transfer on the input carries one command (add/remove task, add/remove
// schedule, tick) and produces one or more results; the final one has last set.
// A non-tick command runs once the output is free. A tick walks the schedule
// table one entry per cycle in id order; a firing result is held pending until
// the next firing or the walk's end so that last can be set on it, and the walk
// stalls while a firing entry meets a pending result and the output is not free.
// A new command is taken once the previous one has loaded its final result.
module periodic_task_timer_table #(
  parameter int unsigned SCHEDULE_SLOTS = 16,
  parameter int unsigned TASK_IDS = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptt_pkg::ptt_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptt_pkg::ptt_out_t  out_data_o
);

  localparam int unsigned Entries = (SCHEDULE_SLOTS < 16) ? SCHEDULE_SLOTS : 16;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;

  ptt_pkg::ptt_cmd_t  cmd;
  ptt_pkg::ptt_stat_t stat;
  logic [IdxW-1:0]    idx;

  ptt_ctrl #(
    .Entries(Entries)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .stat_i     (stat)
  );

  ptt_dp #(
    .SCHEDULE_SLOTS (SCHEDULE_SLOTS),
    .TASK_IDS       (TASK_IDS),
    .TIME_BITS      (TIME_BITS),
    .Entries        (Entries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // a result without a firing is always the only, hence final, one
  a_quiet_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fired |-> out_data_o.last)
    else $error("non-firing result without last");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.status == ptt_pkg::ST_OK)
    else $error("firing result with non-ok status");

  // output register is only loaded when free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec || cmd.finish || (cmd.step && stat.fires && stat.pend_valid)
    |-> stat.out_free)
    else $error("output register overwritten");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> !stat.pend_valid && in_ready_o)
    else $error("pending result left after tick");
`endif

endmodule
